// File: design/csw_pkg.sv
package csw_pkg;

    localparam int NUM_SATS    = 64;
    localparam int WINDOW_MAX  = 256;
    localparam int SAT_W       = 6;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int CNT_W       = 9;
    localparam int CODE_W      = 36;
    localparam int PHASE_W     = 48;
    localparam int TERM_W      = 43;
    localparam int VAL_W       = 48;
    localparam int SUM_W       = 56;
    localparam int DIV_W       = SUM_W + 1;
    localparam int DIVCNT_W    = $clog2(DIV_W + 1);
    localparam int SM_W        = DIV_W + 1;
    localparam int PROD_W      = 64;
    localparam int WIN_W       = 9;
    localparam int THR_W       = 20;
    localparam int WL_W        = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CODE_W-1:0] CODE_MAX   = {CODE_W{1'b1}};
    localparam logic [WIN_W-1:0]  WIN_LIMIT  = WIN_W'(WINDOW_MAX);
    localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(5120);
    localparam logic [WL_W-1:0]   WL_RESET   = WL_W'(817289327);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW     = 2'd0,
        REG_THRESHOLD  = 2'd1,
        REG_WAVELENGTH = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [SAT_W-1:0]          sat_index;
        logic [CODE_W-1:0]         code_range;
        logic signed [PHASE_W-1:0] carrier_phase;
        logic                      arc_start;
    } in_beat_t;

    typedef struct packed {
        logic [SAT_W-1:0]  sat_echo;
        logic [CODE_W-1:0] smoothed_range;
        logic              fell_back;
        logic [CNT_W-1:0]  epochs_used;
    } out_beat_t;

    typedef enum logic [1:0] {
        JOB_PASS,
        JOB_MISS,
        JOB_SMOOTH
    } job_kind_t;

    typedef struct packed {
        logic [SAT_W-1:0]         sat;
        logic [CODE_W-1:0]        code;
        logic signed [TERM_W-1:0] term;
        job_kind_t                kind;
        logic                     arc;
    } job_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [CNT_W-1:0]        count;
        logic [SLOT_W-1:0]       slot;
    } sat_state_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_SUM,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LOAD,
        B_OLD,
        B_UPD,
        B_PREP,
        B_DIV,
        B_SUM,
        B_CHK,
        B_OUT
    } back_state_t;

endpackage

// File: design/carrier_smoothed_code_window.sv
// Carrier-smoothed pseudorange over a per-satellite moving window. Each input
// beat holds one satellite's code range and carrier phase; each produces one
// output beat. The front computes the carrier term in its multiply and sum states and queues
// the job; the back keeps the window ring, sum and count per satellite in RAM
// and divides the window sum by the count with a 57-step restoring divider.
// A smoothed item runs through that divider in the back; a pass-through item
// goes from load straight to output. Writing the window register clears every
// satellite's window; configuration should be written only while the block is idle.
module carrier_smoothed_code_window
    import csw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_beat,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_beat,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WL_W-1:0]      cfg_data
);

    logic [WIN_W-1:0] window_reg;
    logic [THR_W-1:0] threshold_reg;
    logic [WL_W-1:0]  wavelength_reg;
    logic [WIN_W-1:0] win_n;
    logic             clear_all;

    logic             q_push, q_full, q_pop, q_empty;
    job_t             q_in, q_head;

    assign cfg_ready = 1'b1;
    assign clear_all = cfg_valid && (cfg_index == REG_WINDOW);
    assign win_n     = (window_reg > WIN_LIMIT) ? WIN_LIMIT : window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg     <= '0;
            threshold_reg  <= THR_RESET;
            wavelength_reg <= WL_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WINDOW)
            begin
                window_reg <= cfg_data[WIN_W-1:0];
            end
            else if (cfg_index == REG_THRESHOLD)
            begin
                threshold_reg <= cfg_data[THR_W-1:0];
            end
            else if (cfg_index == REG_WAVELENGTH)
            begin
                wavelength_reg <= cfg_data;
            end
        end
    end

    csw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_beat    (in_beat),
        .win_n      (win_n),
        .wavelength (wavelength_reg),
        .push       (q_push),
        .push_job   (q_in),
        .full       (q_full)
    );

    csw_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty)
    );

    csw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (q_empty),
        .head      (q_head),
        .pop       (q_pop),
        .win_n     (win_n),
        .threshold (threshold_reg),
        .clear_all (clear_all),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat)
    );

endmodule

// File: design/csw_ram.sv
module csw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: design/csw_front.sv
module csw_front
    import csw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  in_beat_t          in_beat,
    input  logic [WIN_W-1:0]  win_n,
    input  logic [WL_W-1:0]   wavelength,
    output logic              push,
    output job_t              push_job,
    input  logic              full
);

    front_state_t         state_reg, state_next;
    in_beat_t             beat_reg, beat_next;
    logic [PROD_W-1:0]    p_hi_reg, p_hi_next;
    logic [PROD_W-1:0]    p_lo_reg, p_lo_next;
    logic [PROD_W-1:0]    c_reg, c_next;
    logic                 neg_reg, neg_next;

    logic [PHASE_W-1:0]   mag;
    logic [PROD_W-1:0]    rounded;
    logic [TERM_W-2:0]    t_mag;
    logic [TERM_W-1:0]    t_pos;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
        p_hi_reg <= p_hi_next;
        p_lo_reg <= p_lo_next;
        c_reg    <= c_next;
        neg_reg  <= neg_next;
    end

    // phase magnitude; the most negative phase still fits unsigned
    assign mag = beat_reg.carrier_phase[PHASE_W-1] ?
                 (~beat_reg.carrier_phase + PHASE_W'(1)) : beat_reg.carrier_phase;

    assign rounded = c_reg + PROD_W'(64'd1 << 21);
    assign t_mag   = rounded[TERM_W+20:22];
    assign t_pos   = {1'b0, t_mag};

    always_comb
    begin
        state_next = state_reg;
        beat_next  = beat_reg;
        p_hi_next  = p_hi_reg;
        p_lo_next  = p_lo_reg;
        c_next     = c_reg;
        neg_next   = neg_reg;
        in_ready   = 1'b0;
        push       = 1'b0;

        push_job.sat  = beat_reg.sat_index;
        push_job.code = beat_reg.code_range;
        push_job.term = neg_reg ? (TERM_W'(0) - t_pos) : t_pos;
        push_job.arc  = beat_reg.arc_start;
        if (win_n == '0)
        begin
            push_job.kind = JOB_PASS;
        end
        else if (beat_reg.carrier_phase == '0)
        begin
            push_job.kind = JOB_MISS;
        end
        else
        begin
            push_job.kind = JOB_SMOOTH;
        end

        unique case (state_reg)
            F_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    beat_next  = in_beat;
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                neg_next   = beat_reg.carrier_phase[PHASE_W-1];
                p_hi_next  = PROD_W'(mag) * PROD_W'(wavelength[WL_W-1:16]);
                p_lo_next  = PROD_W'(mag) * PROD_W'(wavelength[15:0]);
                state_next = F_SUM;
            end
            F_SUM:
            begin
                c_next     = p_hi_reg + (p_lo_reg >> 16);
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

endmodule

// File: design/csw_fifo.sv
module csw_fifo
    import csw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    job_t               entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_reg, rd_reg;
    logic [FILL_W-1:0]  fill_reg;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (fill_reg == FILL_W'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign head  = entry_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= bump(wr_reg);
            end
            if (pop && !empty)
            begin
                rd_reg <= bump(rd_reg);
            end
            if ((push && !full) && !(pop && !empty))
            begin
                fill_reg <= fill_reg + FILL_W'(1);
            end
            else if (!(push && !full) && (pop && !empty))
            begin
                fill_reg <= fill_reg - FILL_W'(1);
            end
        end
    end

endmodule

// File: design/csw_back.sv
module csw_back
    import csw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              empty,
    input  job_t              head,
    output logic              pop,
    input  logic [WIN_W-1:0]  win_n,
    input  logic [THR_W-1:0]  threshold,
    input  logic              clear_all,
    output logic              out_valid,
    input  logic              out_ready,
    output out_beat_t         out_beat
);

    localparam int ST_W  = $bits(sat_state_t);
    localparam int WA_W  = $clog2(NUM_SATS * WINDOW_MAX);
    localparam int SA_W  = $clog2(NUM_SATS);

    back_state_t              state_reg, state_next;
    job_t                     job_reg, job_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic signed [VAL_W-1:0]  v_reg, v_next;
    logic [DIV_W-1:0]         dvd_reg, dvd_next;
    logic [CNT_W-1:0]         rem_reg, rem_next;
    logic [DIVCNT_W-1:0]      dcnt_reg, dcnt_next;
    logic                     neg_reg, neg_next;
    logic signed [SM_W-1:0]   sm_reg, sm_next;
    logic [CODE_W-1:0]        res_reg, res_next;
    logic                     fell_reg, fell_next;
    logic [CNT_W-1:0]         used_reg, used_next;
    logic [NUM_SATS-1:0]      valid_reg, valid_next;
    logic                     ov_reg, ov_next;
    out_beat_t                ob_reg, ob_next;

    sat_state_t               st_rdata, cur, st_wdata;
    logic [ST_W-1:0]          st_rraw;
    logic                     st_we, win_we;
    logic [SA_W-1:0]          st_raddr;
    logic [WA_W-1:0]          win_waddr, win_raddr;
    logic [VAL_W-1:0]         win_rdata;
    logic [SLOT_W-1:0]        slot_use, slot_nx;
    logic [CNT_W-1:0]         slot_inc;
    logic signed [SUM_W-1:0]  sum_new;
    logic [SUM_W-1:0]         sum_mag;
    logic [CNT_W:0]           trial;
    logic signed [SM_W-1:0]   mean;
    logic signed [SM_W:0]     diff;
    logic [SM_W:0]            dmag;

    csw_ram #(.WIDTH(ST_W), .DEPTH(NUM_SATS)) u_state_ram (
        .clk   (clk),
        .we    (st_we),
        .waddr (job_reg.sat[SA_W-1:0]),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rraw)
    );

    csw_ram #(.WIDTH(VAL_W), .DEPTH(NUM_SATS * WINDOW_MAX)) u_window_ram (
        .clk   (clk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (v_reg),
        .raddr (win_raddr),
        .rdata (win_rdata)
    );

    assign st_rdata  = st_rraw;
    assign out_valid = ov_reg;
    assign out_beat  = ob_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            valid_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        sum_reg  <= sum_next;
        cnt_reg  <= cnt_next;
        slot_reg <= slot_next;
        v_reg    <= v_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        dcnt_reg <= dcnt_next;
        neg_reg  <= neg_next;
        sm_reg   <= sm_next;
        res_reg  <= res_next;
        fell_reg <= fell_next;
        used_reg <= used_next;
        ob_reg   <= ob_next;
    end

    // a satellite state never written since the last clear, or at an arc start, reads as zero
    assign cur = (valid_reg[job_reg.sat[SA_W-1:0]] && !job_reg.arc) ? st_rdata : '0;
    assign slot_use  = (CNT_W'(cur.slot) >= win_n) ? '0 : cur.slot;
    assign win_raddr = {job_reg.sat[SA_W-1:0], slot_use};
    assign win_waddr = {job_reg.sat[SA_W-1:0], slot_reg};
    assign sum_new   = sum_reg + SUM_W'(v_reg);
    assign slot_inc  = CNT_W'(slot_reg) + CNT_W'(1);
    assign slot_nx   = (slot_inc >= win_n) ? '0 : slot_inc[SLOT_W-1:0];
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign trial     = {rem_reg, dvd_reg[DIV_W-1]};
    assign mean      = neg_reg ? (SM_W'(0) - SM_W'(dvd_reg)) : SM_W'(dvd_reg);
    assign diff      = (SM_W+1)'(sm_reg) - (SM_W+1)'(job_reg.code);
    assign dmag      = diff[SM_W] ? (SM_W+1)'(-diff) : (SM_W+1)'(diff);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        slot_next  = slot_reg;
        v_next     = v_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dcnt_next  = dcnt_reg;
        neg_next   = neg_reg;
        sm_next    = sm_reg;
        res_next   = res_reg;
        fell_next  = fell_reg;
        used_next  = used_reg;
        valid_next = valid_reg;
        ov_next    = ov_reg;
        ob_next    = ob_reg;
        pop        = 1'b0;
        st_raddr   = head.sat[SA_W-1:0];
        st_we      = 1'b0;
        win_we     = 1'b0;
        st_wdata   = '{sum: sum_new, count: cnt_reg, slot: slot_nx};

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    job_next   = head;
                    state_next = B_LOAD;
                end
            end
            B_LOAD:
            begin
                if (job_reg.arc)
                begin
                    valid_next[job_reg.sat[SA_W-1:0]] = 1'b0;
                end
                res_next  = job_reg.code;
                fell_next = 1'b0;
                used_next = '0;
                unique case (job_reg.kind)
                    JOB_PASS:
                    begin
                        state_next = B_OUT;
                    end
                    JOB_MISS:
                    begin
                        valid_next[job_reg.sat[SA_W-1:0]] = 1'b0;
                        fell_next  = 1'b1;
                        state_next = B_OUT;
                    end
                    JOB_SMOOTH:
                    begin
                        sum_next  = cur.sum;
                        slot_next = slot_use;
                        v_next    = VAL_W'(job_reg.code) - VAL_W'(job_reg.term);
                        if (cur.count >= win_n)
                        begin
                            cnt_next   = cur.count;
                            state_next = B_OLD;
                        end
                        else
                        begin
                            cnt_next   = cur.count + CNT_W'(1);
                            state_next = B_UPD;
                        end
                    end
                    default:
                    begin
                        state_next = B_OUT;
                    end
                endcase
            end
            B_OLD:
            begin
                // full window: the oldest value drops out
                sum_next   = sum_reg - SUM_W'($signed(win_rdata));
                state_next = B_UPD;
            end
            B_UPD:
            begin
                win_we     = 1'b1;
                st_we      = 1'b1;
                sum_next   = sum_new;
                valid_next[job_reg.sat[SA_W-1:0]] = 1'b1;
                state_next = B_PREP;
            end
            B_PREP:
            begin
                neg_next   = sum_reg[SUM_W-1];
                dvd_next   = DIV_W'(sum_mag) + DIV_W'(cnt_reg >> 1);
                rem_next   = '0;
                dcnt_next  = DIVCNT_W'(DIV_W);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                // restoring division, one quotient bit per cycle
                if (trial >= (CNT_W+1)'(cnt_reg))
                begin
                    rem_next = CNT_W'(trial - (CNT_W+1)'(cnt_reg));
                    dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[CNT_W-1:0];
                    dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg - DIVCNT_W'(1);
                if (dcnt_reg == DIVCNT_W'(1))
                begin
                    state_next = B_SUM;
                end
            end
            B_SUM:
            begin
                sm_next    = mean + SM_W'(job_reg.term);
                state_next = B_CHK;
            end
            B_CHK:
            begin
                if (dmag > (SM_W+1)'(threshold))
                begin
                    valid_next[job_reg.sat[SA_W-1:0]] = 1'b0;
                    res_next  = job_reg.code;
                    fell_next = 1'b1;
                    used_next = '0;
                end
                else
                begin
                    if (sm_reg[SM_W-1])
                    begin
                        res_next = '0;
                    end
                    else if (sm_reg > SM_W'(CODE_MAX))
                    begin
                        res_next = CODE_MAX;
                    end
                    else
                    begin
                        res_next = sm_reg[CODE_W-1:0];
                    end
                    fell_next = 1'b0;
                    used_next = cnt_reg;
                end
                state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next    = 1'b1;
                    ob_next    = '{sat_echo: job_reg.sat, smoothed_range: res_reg,
                                   fell_back: fell_reg, epochs_used: used_reg};
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (clear_all)
        begin
            valid_next = '0;
        end
    end

endmodule

// File: test/tb_carrier_smoothed_code_window.sv
module tb_carrier_smoothed_code_window;
    import csw_pkg::*;

    localparam int IDLE_LIMIT = 20000;
    localparam int N_RANDOM   = 1600;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    in_beat_t             in_beat;
    logic                 out_valid;
    logic                 out_ready;
    out_beat_t            out_beat;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WL_W-1:0]      cfg_data;

    carrier_smoothed_code_window dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_beat   (in_beat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_beat  (out_beat),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // smoothing state, mirrored per satellite
    logic signed [VAL_W-1:0] ring [NUM_SATS][WINDOW_MAX];
    logic signed [SUM_W-1:0] run_sum [NUM_SATS];
    int unsigned             run_cnt [NUM_SATS];
    int unsigned             next_slot [NUM_SATS];
    logic [WIN_W-1:0]        win_reg;
    logic [THR_W-1:0]        thr_reg;
    logic [WL_W-1:0]         wl_reg;

    in_beat_t  pending_obs [$];
    out_beat_t expected_ranges [$];
    int        errors;
    int        idle_cycles;
    int        burst_left;
    int        gap_left;
    int        stall_mode;
    bit        feeding_done;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic void clear_window(input int s);
        run_sum[s]   = '0;
        run_cnt[s]   = 0;
        next_slot[s] = 0;
    endfunction

    function automatic logic signed [TERM_W-1:0] carrier_offset(input logic [PHASE_W-1:0] raw);
        logic [PHASE_W-1:0] mag;
        logic [95:0]        c;
        logic [95:0]        t;
        mag = raw[PHASE_W-1] ? (~raw + 1'b1) : raw;
        c = 96'(mag) * 96'(wl_reg[31:16]) + ((96'(mag) * 96'(wl_reg[15:0])) >> 16);
        t = (c + (96'd1 << 21)) >> 22;
        return raw[PHASE_W-1] ? -$signed(TERM_W'(t)) : $signed(TERM_W'(t));
    endfunction

    function automatic out_beat_t smooth_obs(input in_beat_t ob);
        out_beat_t               r;
        int unsigned             n;
        int unsigned             s;
        int unsigned             slot;
        logic signed [TERM_W-1:0] t;
        logic signed [63:0]      v;
        logic signed [63:0]      sum;
        logic [63:0]             amag;
        logic [63:0]             q;
        logic signed [63:0]      sm;
        logic signed [63:0]      diff;
        logic [63:0]             dmag;
        s = ob.sat_index;
        n = (win_reg > WIN_LIMIT) ? WINDOW_MAX : win_reg;
        r.sat_echo       = ob.sat_index;
        r.smoothed_range = ob.code_range;
        r.fell_back      = 1'b0;
        r.epochs_used    = '0;
        if (ob.arc_start)
            clear_window(s);
        if (n == 0)
            return r;
        if (ob.carrier_phase == 0)
        begin
            clear_window(s);
            r.fell_back = 1'b1;
            return r;
        end
        t = carrier_offset(ob.carrier_phase);
        v = $signed({28'd0, ob.code_range}) - 64'(t);
        slot = next_slot[s];
        if (slot >= n)
            slot = 0;
        if (run_cnt[s] >= n)
            run_sum[s] = run_sum[s] - ring[s][slot];
        else
            run_cnt[s]++;
        ring[s][slot] = VAL_W'(v);
        run_sum[s] = run_sum[s] + SUM_W'(v);
        slot++;
        next_slot[s] = (slot >= n) ? 0 : slot;
        sum = 64'(run_sum[s]);
        amag = (sum < 0) ? 64'(-sum) : 64'(sum);
        q = (amag + 64'(run_cnt[s] / 2)) / 64'(run_cnt[s]);
        sm = ((sum < 0) ? -$signed(q) : $signed(q)) + 64'(t);
        diff = sm - $signed({28'd0, ob.code_range});
        dmag = (diff < 0) ? 64'(-diff) : 64'(diff);
        if (dmag > 64'(thr_reg))
        begin
            clear_window(s);
            r.fell_back = 1'b1;
        end
        else
        begin
            if (sm < 0)
                r.smoothed_range = '0;
            else if (sm > $signed({28'd0, CODE_MAX}))
                r.smoothed_range = CODE_MAX;
            else
                r.smoothed_range = CODE_W'(sm);
            r.epochs_used = CNT_W'(run_cnt[s]);
        end
        return r;
    endfunction

    // driver: bursts and gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_beat    <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end
            else if (pending_obs.size() > 0)
            begin
                in_beat  <= pending_obs.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 70);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // prediction is done at acceptance so config changes land in order
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            expected_ranges.insert(expected_ranges.size(), smooth_obs(in_beat));
    end

    // monitor and receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode <= 0;
        end
        else
        begin
            if ($urandom_range(0, 299) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                default: out_ready <= ($urandom_range(0, 9) == 0);
            endcase
            if (out_valid && out_ready)
            begin
                if (expected_ranges.size() == 0)
                begin
                    $display("unexpected beat at %0t", $realtime);
                    errors++;
                end
                else
                begin
                    out_beat_t e;
                    e = expected_ranges.pop_front();
                    if (out_beat.sat_echo !== e.sat_echo)
                        report("sat_echo", out_beat.sat_echo, e.sat_echo);
                    if (out_beat.smoothed_range !== e.smoothed_range)
                        report("smoothed_range", out_beat.smoothed_range, e.smoothed_range);
                    if (out_beat.fell_back !== e.fell_back)
                        report("fell_back", out_beat.fell_back, e.fell_back);
                    if (out_beat.epochs_used !== e.epochs_used)
                        report("epochs_used", out_beat.epochs_used, e.epochs_used);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (expected_ranges.size() > 0 || pending_obs.size() > 0 || in_valid)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [WL_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_WINDOW:
            begin
                win_reg = WIN_W'(val);
                for (int s = 0; s < NUM_SATS; s++)
                    clear_window(s);
            end
            REG_THRESHOLD:  thr_reg = THR_W'(val);
            REG_WAVELENGTH: wl_reg = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (pending_obs.size() > 0 || in_valid || expected_ranges.size() > 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic in_beat_t rand_obs(input int sat_hi, input int kind);
        in_beat_t ob;
        ob.sat_index     = SAT_W'($urandom_range(0, sat_hi));
        ob.code_range    = {4'($urandom), $urandom};
        ob.carrier_phase = {16'($urandom), $urandom};
        ob.arc_start     = ($urandom_range(0, 29) == 0);
        if (kind == 1)
            ob.carrier_phase = '0;
        return ob;
    endfunction

    // coherent track: code and phase consistent so smoothing is accepted
    task automatic queue_track(input int sat, input int len);
        logic [35:0]  rng;
        logic [47:0]  ph;
        in_beat_t     ob;
        rng = {4'($urandom_range(1, 14)), $urandom};
        ph  = {1'b0, 15'($urandom), $urandom} | 48'd1;
        if ($urandom_range(0, 1))
            ph = -ph;
        for (int k = 0; k < len; k++)
        begin
            ob.sat_index     = SAT_W'(sat);
            ob.code_range    = rng + 36'($urandom_range(0, 4000)) - 36'd2000;
            ob.carrier_phase = ph;
            ob.arc_start     = (k == 0) && $urandom_range(0, 1);
            if ($urandom_range(0, 40) == 0)
                ob.carrier_phase = '0;
            pending_obs.insert(pending_obs.size(), ob);
            ph  = ph + 48'($urandom_range(0, 50000));
            if (ph == 0)
                ph = 48'd1;
            rng = rng + 36'($urandom_range(0, 20));
        end
    endtask

    initial
    begin
        in_beat_t ob;
        int       left;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_WINDOW;
        cfg_data    = '0;
        errors      = 0;
        idle_cycles = 0;
        win_reg     = '0;
        thr_reg     = THR_RESET;
        wl_reg      = WL_RESET;
        for (int s = 0; s < NUM_SATS; s++)
            clear_window(s);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // window zero: pass-through, extremes of fields
        ob = '{sat_index: '1, code_range: CODE_MAX, carrier_phase: '1, arc_start: 1'b1};
        pending_obs.insert(pending_obs.size(), ob);
        ob = '{sat_index: '0, code_range: '0, carrier_phase: '0, arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        drain();

        write_reg(REG_WINDOW, 32'd4);
        // missing phase, extreme phases, saturation both ways, arc restart
        ob = '{sat_index: 6'd3, code_range: 36'd1000, carrier_phase: '0, arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        ob = '{sat_index: 6'd3, code_range: 36'd0, carrier_phase: 48'h800000000000,
               arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        ob = '{sat_index: 6'd3, code_range: CODE_MAX, carrier_phase: 48'h7FFFFFFFFFFF,
               arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        ob = '{sat_index: 6'd5, code_range: 36'd10, carrier_phase: -48'sd1, arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        ob = '{sat_index: 6'd5, code_range: 36'd10, carrier_phase: -48'sd1, arc_start: 1'b1};
        pending_obs.insert(pending_obs.size(), ob);
        ob = '{sat_index: 6'd6, code_range: CODE_MAX - 36'd2, carrier_phase: 48'd1,
               arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        queue_track(7, 10);
        drain();

        write_reg(REG_THRESHOLD, 32'hFFFFF);
        write_reg(REG_WAVELENGTH, 32'hFFFFFFFF);
        ob = '{sat_index: 6'd9, code_range: 36'd5, carrier_phase: -48'sd100000000,
               arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        ob = '{sat_index: 6'd9, code_range: CODE_MAX - 36'd5,
               carrier_phase: 48'sd100000000, arc_start: 1'b0};
        pending_obs.insert(pending_obs.size(), ob);
        queue_track(10, 6);
        drain();
        write_reg(REG_THRESHOLD, 32'd0);
        write_reg(REG_WAVELENGTH, 32'd0);
        queue_track(11, 4);
        drain();

        // random phases with varied settings, extremes included
        left = N_RANDOM;
        for (int ph = 0; left > 0; ph++)
        begin
            int chunk;
            case (ph % 6)
                0: write_reg(REG_WINDOW, 32'd1);
                1: write_reg(REG_WINDOW, 32'd256);
                2: write_reg(REG_WINDOW, 32'h1FF);
                3: write_reg(REG_WINDOW, 32'($urandom_range(2, 20)));
                4: write_reg(REG_WINDOW, 32'd0);
                default: write_reg(REG_WINDOW, $urandom);
            endcase
            write_reg(REG_THRESHOLD, ($urandom_range(0, 3) == 0) ? $urandom :
                      32'($urandom_range(2000, 20000)));
            write_reg(REG_WAVELENGTH, ($urandom_range(0, 3) == 0) ? $urandom :
                      WL_RESET + 32'($urandom_range(0, 1000000)));
            chunk = (left < 200) ? left : 200;
            for (int k = 0; k < chunk; )
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    pending_obs.insert(pending_obs.size(),
                                       rand_obs(63, $urandom_range(0, 6) == 0));
                    k++;
                end
                else
                begin
                    int len;
                    len = $urandom_range(3, 25);
                    queue_track($urandom_range(0, 63), len);
                    k += len;
                end
            end
            left -= chunk;
            drain();
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
